@@ src/tbrl_pkg.sv @@
// Shared constants, codes and types of the token bucket rate limiter.
`default_nettype none

package tbrl_pkg;

    localparam int TIME_BITS_DEF  = 48;
    localparam int COUNT_BITS_DEF = 32;
    localparam int RATE_BITS      = 16;
    localparam int OUT_BITS       = 32;
    localparam int OUT_DATA_W     = 2 * OUT_BITS;

    typedef logic [1:0] opcode_t;

    localparam opcode_t OP_START   = 2'd0;
    localparam opcode_t OP_REQUEST = 2'd1;
    localparam opcode_t OP_REQUIRE = 2'd2;

    typedef logic cfg_index_t;

    localparam cfg_index_t CFG_TOKEN_RATE      = 1'b0;
    localparam cfg_index_t CFG_BUCKET_CAPACITY = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

`default_nettype wire

@@ src/token_bucket_rate_limiter.sv @@
// Top level of the token bucket rate limiter: sequencer, bucket state and stream ports.
// One beat is taken at a time. A start, an unused opcode or a require at rate zero goes from
// decode straight to the done state, and a refill that reaches capacity straight from the
// elapsed time passes through check and act first. A refill through the bit-serial multiplier
// adds the multiply state, one rate bit per step until the multiplier finishes, and the sum
// state that adds. A require that runs short of tokens then adds the bit-serial divider state
// and the finish state. The next beat is accepted as soon as the sequencer is back in idle,
// while the previous result may still wait in the output register.
`default_nettype none

module token_bucket_rate_limiter #(
    parameter int TIME_BITS  = tbrl_pkg::TIME_BITS_DEF,
    parameter int COUNT_BITS = tbrl_pkg::COUNT_BITS_DEF,
    localparam int IN_W  = ((TIME_BITS + COUNT_BITS + 7) / 8) * 8,
    localparam int CFG_W = (COUNT_BITS > tbrl_pkg::RATE_BITS) ? COUNT_BITS
                                                              : tbrl_pkg::RATE_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // now_ticks, amount, zero padding
    input  logic [IN_W-1:0]                  s_axis_tdata,
    // opcode
    input  tbrl_pkg::opcode_t                s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // granted, wait_ticks
    output logic [tbrl_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // error
    output logic                             m_axis_tuser,
    input  logic                             cfg_we,
    input  tbrl_pkg::cfg_index_t             cfg_index,
    input  logic [CFG_W-1:0]                 cfg_wdata
);
    import tbrl_pkg::*;

    localparam int WW = (TIME_BITS > COUNT_BITS) ? TIME_BITS : COUNT_BITS;
    localparam int SW = WW + 1;
    localparam int PW = COUNT_BITS + RATE_BITS;
    localparam int CW1 = COUNT_BITS + 1;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECODE = 4'd1;
    localparam logic [3:0] ST_CHECK  = 4'd2;
    localparam logic [3:0] ST_MUL    = 4'd3;
    localparam logic [3:0] ST_SUM    = 4'd4;
    localparam logic [3:0] ST_ACT    = 4'd5;
    localparam logic [3:0] ST_DIV    = 4'd6;
    localparam logic [3:0] ST_FIN    = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    logic [3:0]            state_reg;
    logic                  m_valid_reg;
    logic [RATE_BITS-1:0]  rate_reg;
    logic [COUNT_BITS-1:0] cap_reg;
    logic [COUNT_BITS-1:0] tokens_reg;
    logic [TIME_BITS-1:0]  last_reg;

    opcode_t               op_reg;
    logic [TIME_BITS-1:0]  now_reg;
    logic [COUNT_BITS-1:0] amt_reg;
    logic [TIME_BITS-1:0]  t_reg;
    logic [TIME_BITS-1:0]  elapsed_reg;
    logic [OUT_BITS-1:0]   res_granted_reg;
    logic [OUT_BITS-1:0]   res_wait_reg;
    logic                  res_error_reg;
    logic [OUT_BITS-1:0]   m_granted_reg;
    logic [OUT_BITS-1:0]   m_wait_reg;
    logic                  m_error_reg;

    logic                  accept;
    logic                  out_free;
    logic                  stale;
    logic                  refill_full;
    logic                  short_of;
    logic [COUNT_BITS-1:0] grant_min;
    logic [CW1-1:0]        tok_sum;
    logic [COUNT_BITS-1:0] refill_val;
    logic [SW-1:0]         time_sum;
    logic [TIME_BITS-1:0]  last_wait;
    logic [OUT_BITS-1:0]   wait_sat;

    logic [PW-1:0]         product;
    logic [COUNT_BITS-1:0] quotient;
    unit_status_t          mul_status;
    unit_status_t          div_status;
    logic                  mul_start;
    logic                  div_start;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign stale       = now_reg < last_reg;
    assign refill_full = (rate_reg != '0) && (WW'(elapsed_reg) >= WW'(cap_reg));
    assign short_of    = amt_reg > tokens_reg;
    assign grant_min   = (tokens_reg < amt_reg) ? tokens_reg : amt_reg;

    assign tok_sum    = CW1'(tokens_reg) + CW1'(product[COUNT_BITS-1:0]);
    assign refill_val = (product >= PW'(cap_reg) || tok_sum > CW1'(cap_reg))
                      ? cap_reg : tok_sum[COUNT_BITS-1:0];

    assign time_sum  = SW'(t_reg) + SW'(quotient);
    assign last_wait = (time_sum > SW'({TIME_BITS{1'b1}})) ? {TIME_BITS{1'b1}}
                                                           : time_sum[TIME_BITS-1:0];
    assign wait_sat  = ((quotient >> OUT_BITS) != '0) ? {OUT_BITS{1'b1}}
                                                      : OUT_BITS'(quotient);

    assign mul_start = (state_reg == ST_CHECK) && !refill_full;
    assign div_start = (state_reg == ST_ACT) && (op_reg == OP_REQUIRE) && short_of;

    tbrl_mul #(
        .A_BITS (COUNT_BITS)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (COUNT_BITS'(elapsed_reg)),
        .mplier  (rate_reg),
        .product (product),
        .status  (mul_status)
    );

    tbrl_div #(
        .N_BITS (COUNT_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (amt_reg - tokens_reg),
        .divisor  (rate_reg),
        .quotient (quotient),
        .status   (div_status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            rate_reg    <= '0;
            cap_reg     <= '0;
            tokens_reg  <= '0;
            last_reg    <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_TOKEN_RATE:      rate_reg <= RATE_BITS'(cfg_wdata);
                    CFG_BUCKET_CAPACITY: cap_reg  <= COUNT_BITS'(cfg_wdata);
                    default:             ;
                endcase
            end
            if (m_valid_reg && m_axis_tready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    case (op_reg)
                        OP_START: begin
                            tokens_reg <= cap_reg;
                            last_reg   <= now_reg;
                            state_reg  <= ST_DONE;
                        end
                        OP_REQUEST: state_reg <= ST_CHECK;
                        OP_REQUIRE: state_reg <= (rate_reg == '0) ? ST_DONE : ST_CHECK;
                        default:    state_reg <= ST_DONE;
                    endcase
                end
                ST_CHECK: begin
                    if (refill_full) begin
                        tokens_reg <= cap_reg;
                        state_reg  <= ST_ACT;
                    end else begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (mul_status.done) begin
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    tokens_reg <= refill_val;
                    state_reg  <= ST_ACT;
                end
                ST_ACT: begin
                    if (op_reg == OP_REQUEST) begin
                        tokens_reg <= tokens_reg - grant_min;
                        last_reg   <= t_reg;
                        state_reg  <= ST_DONE;
                    end else if (!short_of) begin
                        tokens_reg <= tokens_reg - amt_reg;
                        last_reg   <= t_reg;
                        state_reg  <= ST_DONE;
                    end else begin
                        tokens_reg <= '0;
                        state_reg  <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_status.done) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    last_reg  <= last_wait;
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_reg  <= s_axis_tuser;
                    now_reg <= s_axis_tdata[TIME_BITS-1:0];
                    amt_reg <= s_axis_tdata[TIME_BITS+COUNT_BITS-1:TIME_BITS];
                end
            end
            ST_DECODE: begin
                t_reg           <= stale ? last_reg : now_reg;
                elapsed_reg     <= stale ? '0 : (now_reg - last_reg);
                res_granted_reg <= '0;
                res_wait_reg    <= '0;
                res_error_reg   <= (op_reg == OP_REQUIRE) && (rate_reg == '0);
            end
            ST_ACT: begin
                if (op_reg == OP_REQUEST) begin
                    res_granted_reg <= OUT_BITS'(grant_min);
                end else begin
                    res_granted_reg <= OUT_BITS'(amt_reg);
                end
            end
            ST_FIN: begin
                res_wait_reg <= wait_sat;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_granted_reg <= res_granted_reg;
                    m_wait_reg    <= res_wait_reg;
                    m_error_reg   <= res_error_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_wait_reg, m_granted_reg};
    assign m_axis_tuser  = m_error_reg;

endmodule

`default_nettype wire

@@ src/tbrl_mul.sv @@
// Bit-serial shift-and-add multiplier, one bit of the rate per cycle.
`default_nettype none

module tbrl_mul #(
    parameter int A_BITS = tbrl_pkg::COUNT_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    start,
    input  logic [A_BITS-1:0]                       mcand,
    input  logic [tbrl_pkg::RATE_BITS-1:0]          mplier,
    output logic [A_BITS+tbrl_pkg::RATE_BITS-1:0]   product,
    output tbrl_pkg::unit_status_t                  status
);
    import tbrl_pkg::*;

    localparam int PW = A_BITS + RATE_BITS;
    localparam int CW = $clog2(RATE_BITS + 1);

    logic [A_BITS-1:0]    mcand_reg;
    logic [RATE_BITS-1:0] mplier_reg;
    logic [PW-1:0]        acc_reg;
    logic [PW-1:0]        acc_next;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    assign acc_next = {acc_reg[PW-2:0], 1'b0}
                    + (mplier_reg[RATE_BITS-1] ? PW'(mcand_reg) : PW'(0));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(RATE_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mcand_reg  <= mcand;
            mplier_reg <= mplier;
            acc_reg    <= '0;
        end else if (busy_reg) begin
            mplier_reg <= {mplier_reg[RATE_BITS-2:0], 1'b0};
            acc_reg    <= acc_next;
        end
    end

    assign product     = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

@@ src/tbrl_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module tbrl_div #(
    parameter int N_BITS = tbrl_pkg::COUNT_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [N_BITS-1:0]               dividend,
    input  logic [tbrl_pkg::RATE_BITS-1:0]  divisor,
    output logic [N_BITS-1:0]               quotient,
    output tbrl_pkg::unit_status_t          status
);
    import tbrl_pkg::*;

    localparam int CW = $clog2(N_BITS + 1);

    logic [N_BITS-1:0]    dvd_reg;
    logic [N_BITS-1:0]    dvd_next;
    logic [RATE_BITS-1:0] dvs_reg;
    logic [RATE_BITS-1:0] rem_reg;
    logic [RATE_BITS-1:0] rem_next;
    logic [RATE_BITS:0]   trial;
    logic [RATE_BITS:0]   diff;
    logic                 fits;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    assign trial    = {rem_reg, dvd_reg[N_BITS-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign fits     = trial >= {1'b0, dvs_reg};
    assign rem_next = fits ? diff[RATE_BITS-1:0] : trial[RATE_BITS-1:0];
    assign dvd_next = {dvd_reg[N_BITS-2:0], fits};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(N_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient    = dvd_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

@@ src/tbrl_checker.sv @@
// Port-level assertions of the token bucket rate limiter and their bind to the top level.
`default_nettype none

module tbrl_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [tbrl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tuser
);
    import tbrl_pkg::*;

    // The output beat is cleared by reset.
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled output beat changed");

    // One beat at a time: an accepted beat closes the input until its work is done.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while busy");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("error beat carries a grant or a wait");

    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared while idle");

endmodule

bind token_bucket_rate_limiter tbrl_checker u_tbrl_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ tb/token_bucket_rate_limiter_checker.sv @@
// Bucket state tracker that predicts every grant and compares it with the result beats.
`default_nettype none

module token_bucket_rate_limiter_checker
    import tbrl_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    // now_ticks, amount
    input  wire logic [79:0] s_axis_tdata,
    // opcode
    input  wire opcode_t     s_axis_tuser,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // granted, wait_ticks
    input  wire logic [63:0] m_axis_tdata,
    // error
    input  wire logic        m_axis_tuser,
    input  wire logic        cfg_we,
    input  wire cfg_index_t  cfg_index,
    input  wire logic [31:0] cfg_wdata,
    output logic [31:0]      fail_count,
    output logic [31:0]      outstanding
);

    typedef struct packed {
        logic [31:0] granted;
        logic [31:0] wait_ticks;
        logic        rate_error;
    } grant_result_t;

    localparam logic [47:0] TIME_MAX = '1;

    logic [15:0]   rate_cfg;
    logic [31:0]   cap_cfg;
    logic [31:0]   tokens_left;
    logic [47:0]   stamp_time;
    grant_result_t pending_grants[$];

    function automatic logic [47:0] refill_bucket(input logic [47:0] now);
        logic [47:0] eff;
        logic [63:0] elapsed;
        logic [63:0] total;
        eff = now;
        if (now < stamp_time) begin
            eff = stamp_time;
            elapsed = '0;
        end else begin
            elapsed = 64'(now - stamp_time);
        end
        if (rate_cfg != 0 && elapsed >= 64'(cap_cfg)) begin
            tokens_left = cap_cfg;
        end else begin
            total = 64'(tokens_left) + elapsed * 64'(rate_cfg);
            tokens_left = (total > 64'(cap_cfg)) ? cap_cfg : total[31:0];
        end
        return eff;
    endfunction

    function automatic grant_result_t predict_bucket(input opcode_t op, input logic [47:0] now,
                                                     input logic [31:0] amount);
        grant_result_t res;
        logic [47:0]   eff;
        logic [63:0]   shortfall_ticks;
        res = '0;
        case (op)
            OP_START: begin
                tokens_left = cap_cfg;
                stamp_time = now;
            end
            OP_REQUEST: begin
                eff = refill_bucket(now);
                res.granted = (tokens_left < amount) ? tokens_left : amount;
                tokens_left = tokens_left - res.granted;
                stamp_time = eff;
            end
            OP_REQUIRE: begin
                if (rate_cfg == 0) begin
                    res.rate_error = 1'b1;
                end else begin
                    eff = refill_bucket(now);
                    res.granted = amount;
                    if (amount <= tokens_left) begin
                        tokens_left = tokens_left - amount;
                        stamp_time = eff;
                    end else begin
                        shortfall_ticks = 64'(amount - tokens_left) / 64'(rate_cfg);
                        tokens_left = '0;
                        if (shortfall_ticks > 64'(TIME_MAX - eff)) begin
                            stamp_time = TIME_MAX;
                        end else begin
                            stamp_time = eff + shortfall_ticks[47:0];
                        end
                        res.wait_ticks = (shortfall_ticks > 64'hFFFF_FFFF) ? '1
                                                                         : shortfall_ticks[31:0];
                    end
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic int field_differs(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
        if (got === want) begin
            return 0;
        end
        $error("%s: expected %0d, actual %0d", field, want, got);
        return 1;
    endfunction

    always @(posedge aclk) begin
        grant_result_t got;
        grant_result_t want;
        int            errs;
        errs = 0;
        if (!aresetn) begin
            rate_cfg = '0;
            cap_cfg = '0;
            tokens_left = '0;
            stamp_time = '0;
            pending_grants.delete();
            fail_count <= '0;
            outstanding <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_TOKEN_RATE:      rate_cfg = cfg_wdata[15:0];
                    CFG_BUCKET_CAPACITY: cap_cfg = cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser};
                if (pending_grants.size() == 0) begin
                    $error("result beat with no grant pending: granted %0d, wait_ticks %0d",
                           got.granted, got.wait_ticks);
                    errs++;
                end else begin
                    want = pending_grants.pop_front();
                    errs += field_differs("granted", want.granted, got.granted);
                    errs += field_differs("wait_ticks", want.wait_ticks, got.wait_ticks);
                    errs += field_differs("error", 32'(want.rate_error), 32'(got.rate_error));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pending_grants.push_back(predict_bucket(s_axis_tuser, s_axis_tdata[47:0],
                                                        s_axis_tdata[79:48]));
            end
            fail_count <= fail_count + 32'(errs);
            outstanding <= 32'(pending_grants.size());
        end
    end

endmodule

`default_nettype wire

@@ tb/token_bucket_rate_limiter_test.sv @@
// Top of the rate limiter testbench: clock, reset, stimulus, back-pressure and the verdict.
`default_nettype none

module token_bucket_rate_limiter_test;
    import tbrl_pkg::*;

    localparam opcode_t     OP_UNUSED    = 2'd3;
    localparam logic [47:0] TIME_MAX     = '1;
    localparam int          PHASES       = 8;
    localparam int          PHASE_ITEMS  = 81;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_PAD    = 8;
    localparam int          END_PAD      = 100;
    localparam int          STALL_LIMIT  = 3000;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic [79:0]   s_axis_tdata = '0;
    opcode_t       s_axis_tuser = OP_START;
    logic          m_axis_tready = 1'b0;
    logic          cfg_we = 1'b0;
    cfg_index_t    cfg_index = CFG_TOKEN_RATE;
    logic [31:0]   cfg_wdata = '0;
    wire           s_axis_tready;
    wire           m_axis_tvalid;
    wire  [63:0]   m_axis_tdata;
    wire           m_axis_tuser;
    wire  [31:0]   fail_count;
    wire  [31:0]   outstanding;

    int            tx_idle_pct = 0;
    int            rx_idle_pct = 0;
    logic          hold_req = 1'b0;
    logic [47:0]   tick_now = '0;
    logic [31:0]   cap_now = '0;
    int            idle_cycles = 0;

    token_bucket_rate_limiter i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    token_bucket_rate_limiter_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("token_bucket_rate_limiter: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_beat(input opcode_t op, input logic [47:0] now, input logic [31:0] amount);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {amount, now};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic drain_results(input int pad);
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (pad) @(posedge aclk);
    endtask

    task automatic set_config(input logic [15:0] rate, input logic [31:0] cap);
        drain_results(DRAIN_PAD);
        cfg_we <= 1'b1;
        cfg_index <= CFG_TOKEN_RATE;
        cfg_wdata <= {16'($urandom), rate};
        @(posedge aclk);
        cfg_index <= CFG_BUCKET_CAPACITY;
        cfg_wdata <= cap;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cap_now = cap;
    endtask

    task automatic random_beat();
        opcode_t     op;
        logic [47:0] now;
        logic [31:0] amount;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            op = OP_START;
        end else if (pick < 11) begin
            op = OP_UNUSED;
        end else if (pick < 52) begin
            op = OP_REQUEST;
        end else begin
            op = OP_REQUIRE;
        end
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            tick_now = tick_now + 48'($urandom_range(0, 40));
        end else if (pick < 80) begin
            tick_now = tick_now + 48'($urandom_range(0, 100000));
        end else if (pick < 86) begin
            tick_now = tick_now + 48'($urandom);
        end else if (pick < 90) begin
            tick_now = {16'($urandom), $urandom};
        end
        now = tick_now;
        if (pick >= 90) begin
            now = tick_now - 48'($urandom_range(1, 100));
        end
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            amount = 32'($urandom % (64'(cap_now) + 64'd1));
        end else if (pick < 65) begin
            amount = 32'($urandom_range(0, 64));
        end else if (pick < 75) begin
            amount = '0;
        end else if (pick < 85) begin
            amount = '1;
        end else begin
            amount = $urandom;
        end
        send_beat(op, now, amount);
    endtask

    initial begin
        logic [15:0] rate;
        logic [31:0] cap;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_beat(OP_REQUIRE, 48'd5, 32'd10);
        send_beat(OP_REQUEST, 48'd7, 32'd10);
        send_beat(OP_UNUSED, TIME_MAX, '1);
        send_beat(OP_START, 48'd100, '1);

        set_config(16'd3, 32'd1000);
        send_beat(OP_START, 48'd10, 32'd0);
        send_beat(OP_REQUEST, 48'd10, 32'd400);
        send_beat(OP_REQUEST, 48'd5, '1);
        send_beat(OP_REQUIRE, 48'd20, 32'd100);
        send_beat(OP_REQUEST, 48'd43, 32'd0);
        send_beat(OP_REQUIRE, 48'd2000, 32'd1000);

        set_config(16'd1, '1);
        send_beat(OP_START, TIME_MAX - 48'd5, 32'd0);
        send_beat(OP_REQUIRE, TIME_MAX - 48'd5, '1);
        send_beat(OP_REQUIRE, TIME_MAX - 48'd5, '1);
        send_beat(OP_REQUEST, 48'd0, 32'd1);
        send_beat(OP_REQUEST, TIME_MAX, 32'd1);

        set_config(16'hFFFF, '1);
        send_beat(OP_START, 48'd0, 32'd0);
        set_config(16'hFFFF, 32'd1);
        send_beat(OP_REQUEST, 48'd0, 32'd0);
        send_beat(OP_REQUEST, 48'd0, 32'd2);
        send_beat(OP_REQUIRE, 48'd1, 32'd2);

        set_config(16'd0, 32'd500);
        send_beat(OP_REQUIRE, 48'd100, 32'd5);
        send_beat(OP_REQUEST, 48'd200, 32'd5);
        send_beat(OP_START, 48'd300, 32'd0);
        send_beat(OP_REQUEST, 48'd400, 32'd499);

        tick_now = 48'd1000;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    rate = 16'($urandom_range(1, 8));
                    cap = $urandom_range(50, 2000);
                end
                1: begin
                    rate = 16'hFFFF;
                    cap = '1;
                end
                2: begin
                    rate = 16'd1;
                    cap = $urandom_range(1, 100);
                end
                3: begin
                    rate = 16'($urandom_range(1, 16));
                    cap = '0;
                end
                4: begin
                    rate = '0;
                    cap = $urandom;
                end
                5: begin
                    rate = 16'($urandom);
                    cap = $urandom;
                end
                6: begin
                    rate = 16'($urandom_range(1, 300));
                    cap = $urandom_range(1000, 100000);
                end
                default: begin
                    rate = 16'($urandom_range(1, 4));
                    cap = $urandom_range(100, 5000);
                end
            endcase
            set_config(rate, cap);
            tx_idle_pct = (phase == 2 || phase == PHASES - 1) ? 0 : 35;
            rx_idle_pct = (phase == 2 || phase == PHASES - 1) ? 0 : 6;
            if (phase == 6) begin
                hold_req = 1'b1;
            end
            send_beat(OP_START, tick_now, 32'd0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 5 && n == 40) begin
                    drain_results(0);
                end
                random_beat();
            end
        end

        drain_results(END_PAD);
        if (fail_count == 0 && outstanding == 0) begin
            $display("token_bucket_rate_limiter: match");
        end else begin
            $display("token_bucket_rate_limiter: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
